// File: rtl/scpa_pkg.sv
// Shared types and constants of the size class pool allocator.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package scpa_pkg;

  // Operation carried by a request.
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_e;

  // Size class codes.
  localparam logic [1:0] CLS_SMALL = 2'd0;
  localparam logic [1:0] CLS_MID   = 2'd1;
  localparam logic [1:0] CLS_LARGE = 2'd2;

  // Block sizes in bytes and their log2.
  localparam int unsigned SIZE_SMALL  = 16;
  localparam int unsigned SIZE_MID    = 32;
  localparam int unsigned SIZE_LARGE  = 64;
  localparam int unsigned SHIFT_SMALL = 4;
  localparam int unsigned SHIFT_MID   = 5;
  localparam int unsigned SHIFT_LARGE = 6;

  // Register index of the configuration port.
  localparam logic REG_POOL_BASE = 1'b0;

  // Command from the allocator core to one free list.
  typedef struct packed {
    logic pop;
    logic push;
  } list_cmd_t;

endpackage

// File: rtl/scpa_free_list.sv
// One LIFO free list: a head index and one link index per block.
// Depends on scpa_pkg for the list command struct.
`timescale 1ns / 1ps

module scpa_free_list import scpa_pkg::*; #(
  parameter int unsigned COUNT = 8,
  parameter int unsigned IDX_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  list_cmd_t        cmd_i,
  input  logic [IDX_W-1:0] push_idx_i,
  output logic [IDX_W-1:0] head_o
);

  localparam int unsigned AW = (COUNT > 1) ? $clog2(COUNT) : 1;

  logic [IDX_W-1:0] head_q;
  logic [IDX_W-1:0] links_q [COUNT];

  assign head_o = head_q;

  // A pop is only issued when the head names a real block, a push only with
  // an index inside the list, so the part-selects never alias.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      for (int i = 0; i < COUNT; i++) begin
        links_q[i] <= IDX_W'(i + 1);
      end
    end else if (cmd_i.push) begin
      links_q[push_idx_i[AW-1:0]] <= head_q;
      head_q                      <= push_idx_i;
    end else if (cmd_i.pop) begin
      head_q <= links_q[head_q[AW-1:0]];
    end
  end

endmodule

// File: rtl/size_class_pool_allocator_unit.sv
// Top level of the size class pool allocator: request register, class
// selection and address decode, result register and configuration port.
// Depends on scpa_pkg and scpa_free_list.
`timescale 1ns / 1ps

// Usage
// A request is taken at a rising edge where start is high and busy is low.
// busy is held low: the block takes a new request in every cycle. The request
// is registered, then logic selects the class, pops or pushes the free list and
// registers the result, which is shown for one cycle with result_valid_o high.
// Sustained rate is one request per cycle, set by the single read-modify-write
// of each list head per cycle. The receiver cannot stall; results are never
// held back. pool_base is written over the APB-style port at byte address 0;
// the user must write it only while no request is in flight, which the block
// does not enforce. pready is always high; reads return pool_base, or zero
// when paddr[2] is set. Reset empties the request and result stages, sets
// pool_base to zero and rebuilds every free list in address order, all at
// once; no clearing pass.

module size_class_pool_allocator_unit import scpa_pkg::*; #(
  parameter int unsigned SMALL_COUNT  = 8,
  parameter int unsigned MID_COUNT    = 8,
  parameter int unsigned LARGE_COUNT  = 4,
  parameter int unsigned HEADER_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [15:0] request_bytes_i,
  input  logic [31:0] block_address_i,
  // Result channel.
  output logic        result_valid_o,
  output logic [31:0] granted_address_o,
  output logic [1:0]  size_class_o,
  output logic [1:0]  status_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SW = $clog2(SMALL_COUNT + 1);
  localparam int unsigned MW = $clog2(MID_COUNT + 1);
  localparam int unsigned LW = $clog2(LARGE_COUNT + 1);

  // Largest request each class can hold, and the byte span of each class.
  localparam logic [15:0] FIT_SMALL = 16'(SIZE_SMALL - HEADER_BYTES);
  localparam logic [15:0] FIT_MID   = 16'(SIZE_MID - HEADER_BYTES);
  localparam logic [15:0] FIT_LARGE = 16'(SIZE_LARGE - HEADER_BYTES);
  localparam logic [31:0] SPAN_SMALL = 32'(SMALL_COUNT * SIZE_SMALL);
  localparam logic [31:0] SPAN_MID   = 32'(MID_COUNT * SIZE_MID);
  localparam logic [31:0] SPAN_LARGE = 32'(LARGE_COUNT * SIZE_LARGE);
  localparam logic [31:0] HDR        = 32'(HEADER_BYTES);

  // Configuration register.
  logic [31:0] pool_base_q;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_BASE);
  assign prdata    = (paddr[2] == REG_POOL_BASE) ? pool_base_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
    end else if (cfg_write) begin
      pool_base_q <= pwdata;
    end
  end

  // Request register. The lists update at the same edge that registers a
  // result, so the next request always sees the state its predecessor left.
  logic        in_valid_q;
  logic        func_q;
  logic [15:0] req_q;
  logic [31:0] addr_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q <= func_i;
      req_q  <= request_bytes_i;
      addr_q <= block_address_i;
    end
  end

  // Free lists.
  list_cmd_t small_cmd, mid_cmd, large_cmd;
  logic [SW-1:0] small_head, small_idx;
  logic [MW-1:0] mid_head, mid_idx;
  logic [LW-1:0] large_head, large_idx;

  scpa_free_list #(.COUNT(SMALL_COUNT), .IDX_W(SW)) u_small_list (
    .clk_i, .rst_ni, .cmd_i(small_cmd), .push_idx_i(small_idx), .head_o(small_head)
  );
  scpa_free_list #(.COUNT(MID_COUNT), .IDX_W(MW)) u_mid_list (
    .clk_i, .rst_ni, .cmd_i(mid_cmd), .push_idx_i(mid_idx), .head_o(mid_head)
  );
  scpa_free_list #(.COUNT(LARGE_COUNT), .IDX_W(LW)) u_large_list (
    .clk_i, .rst_ni, .cmd_i(large_cmd), .push_idx_i(large_idx), .head_o(large_head)
  );

  // Free address decode: offset from the pool start, then from each class.
  logic [31:0] off_small, off_mid, off_large;

  assign off_small = addr_q - HDR - pool_base_q;
  assign off_mid   = off_small - SPAN_SMALL;
  assign off_large = off_mid - SPAN_MID;
  assign small_idx = SW'(off_small >> SHIFT_SMALL);
  assign mid_idx   = MW'(off_mid >> SHIFT_MID);
  assign large_idx = LW'(off_large >> SHIFT_LARGE);

  // Request evaluation.
  logic [31:0] granted_d;
  logic [1:0]  class_d;
  status_e     status_d;

  always_comb begin
    small_cmd = '0;
    mid_cmd   = '0;
    large_cmd = '0;
    granted_d = '0;
    class_d   = CLS_SMALL;
    status_d  = ST_TOO_LARGE;
    if (func_e'(func_q) == FUNC_ALLOC) begin
      // The first class that fits serves the request; a larger class is
      // never tried when that one is exhausted.
      if (req_q <= FIT_SMALL) begin
        class_d = CLS_SMALL;
        if (32'(small_head) >= 32'(SMALL_COUNT)) begin
          status_d = ST_EXHAUSTED;
        end else begin
          status_d      = ST_OK;
          small_cmd.pop = in_valid_q;
          granted_d     = pool_base_q + (32'(small_head) << SHIFT_SMALL) + HDR;
        end
      end else if (req_q <= FIT_MID) begin
        class_d = CLS_MID;
        if (32'(mid_head) >= 32'(MID_COUNT)) begin
          status_d = ST_EXHAUSTED;
        end else begin
          status_d    = ST_OK;
          mid_cmd.pop = in_valid_q;
          granted_d   = pool_base_q + SPAN_SMALL + (32'(mid_head) << SHIFT_MID) + HDR;
        end
      end else if (req_q <= FIT_LARGE) begin
        class_d = CLS_LARGE;
        if (32'(large_head) >= 32'(LARGE_COUNT)) begin
          status_d = ST_EXHAUSTED;
        end else begin
          status_d      = ST_OK;
          large_cmd.pop = in_valid_q;
          granted_d     = pool_base_q + SPAN_SMALL + SPAN_MID
                          + (32'(large_head) << SHIFT_LARGE) + HDR;
        end
      end
    end else begin
      // The address must land on a block start inside the class region it
      // falls in; otherwise nothing changes and the free is reported bad.
      status_d = ST_BAD_FREE;
      if (off_small < SPAN_SMALL) begin
        if (off_small[SHIFT_SMALL-1:0] == '0) begin
          status_d       = ST_OK;
          class_d        = CLS_SMALL;
          small_cmd.push = in_valid_q;
        end
      end else if (off_mid < SPAN_MID) begin
        if (off_mid[SHIFT_MID-1:0] == '0) begin
          status_d     = ST_OK;
          class_d      = CLS_MID;
          mid_cmd.push = in_valid_q;
        end
      end else if (off_large < SPAN_LARGE) begin
        if (off_large[SHIFT_LARGE-1:0] == '0) begin
          status_d       = ST_OK;
          class_d        = CLS_LARGE;
          large_cmd.push = in_valid_q;
        end
      end
    end
  end

  // Result register: one strobe per request, registered from the evaluation.
  logic        res_valid_q;
  logic [31:0] granted_q;
  logic [1:0]  class_q;
  status_e     status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      granted_q <= granted_d;
      class_q   <= class_d;
      status_q  <= status_d;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign granted_address_o = granted_q;
  assign size_class_o      = class_q;
  assign status_o          = status_q;

endmodule

// File: test/size_class_pool_allocator_unit_tb.sv
// Self-checking testbench for the size class pool allocator: directed and random requests,
// predicted results checked in order, pool_base rewritten between phases. Depends on scpa_pkg
// and the RTL of size_class_pool_allocator_unit, which in turn needs scpa_free_list.
`timescale 1ns / 1ps

module size_class_pool_allocator_unit_tb;
  import scpa_pkg::*;

  localparam int unsigned SMALL_BLOCKS = 8;
  localparam int unsigned MID_BLOCKS   = 8;
  localparam int unsigned LARGE_BLOCKS = 4;
  localparam int unsigned HDR          = 8;

  // Register 0 sits at byte address 0 of the configuration port.
  localparam logic [2:0] ADDR_POOL_BASE = {REG_POOL_BASE, 2'b00};

  localparam int unsigned RANDOM_PER_PHASE = 205;
  localparam int unsigned PHASE_COUNT      = 6;
  // The result passes the request and result registers after the accepting edge; the drain adds a margin.
  localparam int unsigned DRAIN_CYCLES     = 6;
  localparam int unsigned CYCLE_LIMIT      = 100000;

  // Software image of the allocator: base address, one head per class and one link per block.
  // An index equal to the class block count marks an empty list.
  typedef struct packed {
    logic [31:0]           base;
    logic [2:0][3:0]       head;
    logic [2:0][15:0][3:0] links;
  } pool_state_t;

  typedef struct packed {
    logic [31:0] granted;
    logic [1:0]  cls;
    status_e     status;
  } grant_t;

  typedef struct packed {
    func_e       op;
    logic [15:0] bytes;
    logic [31:0] addr;
  } pool_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        func_i = FUNC_ALLOC;
  logic [15:0] request_bytes_i = '0;
  logic [31:0] block_address_i = '0;
  logic        result_valid_o;
  logic [31:0] granted_address_o;
  logic [1:0]  size_class_o;
  logic [1:0]  status_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Requests waiting for the driver, and the results predicted for accepted requests.
  pool_req_t   req_q[$];
  grant_t      grant_q[$];
  // Addresses the generator believes are currently handed out.
  logic [31:0] live_q[$];

  // The checker's image follows accepted requests; the generator's image runs ahead of it
  // so that frees can be aimed at blocks that were really granted.
  pool_state_t chk_state;
  pool_state_t gen_state;

  int unsigned idle_pct = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  logic        req_taken = 1'b0;

  size_class_pool_allocator_unit #(
    .SMALL_COUNT  (SMALL_BLOCKS),
    .MID_COUNT    (MID_BLOCKS),
    .LARGE_COUNT  (LARGE_BLOCKS),
    .HEADER_BYTES (HDR)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .request_bytes_i   (request_bytes_i),
    .block_address_i   (block_address_i),
    .result_valid_o    (result_valid_o),
    .granted_address_o (granted_address_o),
    .size_class_o      (size_class_o),
    .status_o          (status_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned class_size(input int unsigned c);
    case (c)
      0:       return SIZE_SMALL;
      1:       return SIZE_MID;
      default: return SIZE_LARGE;
    endcase
  endfunction

  function automatic int unsigned class_count(input int unsigned c);
    case (c)
      0:       return SMALL_BLOCKS;
      1:       return MID_BLOCKS;
      default: return LARGE_BLOCKS;
    endcase
  endfunction

  // Classes lie back to back: all small blocks, then all mid blocks, then the large ones.
  function automatic logic [31:0] class_start(input logic [31:0] base, input int unsigned c);
    logic [31:0] off;
    off = '0;
    if (c >= 1) off = off + SMALL_BLOCKS * SIZE_SMALL;
    if (c >= 2) off = off + MID_BLOCKS * SIZE_MID;
    return base + off;
  endfunction

  // Address that an allocate of block idx in class c hands out, just past the header.
  function automatic logic [31:0] block_addr(input logic [31:0] base, input int unsigned c,
                                             input int unsigned idx);
    return class_start(base, c) + idx * class_size(c) + HDR;
  endfunction

  // After reset each list runs in address order and its last block links to "none".
  function automatic pool_state_t pool_reset_state();
    pool_state_t s;
    s = '0;
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < class_count(c); i++) s.links[c][i] = 4'(i + 1);
    end
    return s;
  endfunction

  // Serves one request against the image s and returns the result the block must produce.
  function automatic grant_t pool_serve(inout pool_state_t s, input func_e op,
                                        input logic [15:0] bytes, input logic [31:0] addr);
    grant_t      r;
    logic [31:0] sz;
    logic [31:0] span;
    logic [31:0] off;
    logic [3:0]  idx;
    logic        done;
    r.granted = '0;
    r.cls     = CLS_SMALL;
    done      = 1'b0;
    if (op == FUNC_ALLOC) begin
      // The first class that fits is the only one tried, even when its list is empty.
      r.status = ST_TOO_LARGE;
      for (int c = 0; c < 3; c++) begin
        sz = class_size(c);
        if (!done && {16'd0, bytes} <= sz - HDR) begin
          done  = 1'b1;
          r.cls = 2'(c);
          if (s.head[c] >= class_count(c)) begin
            r.status = ST_EXHAUSTED;
          end else begin
            r.granted = class_start(s.base, c) + s.head[c] * sz + HDR;
            s.head[c] = s.links[c][s.head[c]];
            r.status  = ST_OK;
          end
        end
      end
    end else begin
      // The offset wraps, so an address below the pool lands far above it and is rejected.
      r.status = ST_BAD_FREE;
      off      = addr - HDR - s.base;
      for (int c = 0; c < 3; c++) begin
        sz   = class_size(c);
        span = class_count(c) * sz;
        if (!done) begin
          if (off < span) begin
            done = 1'b1;
            if ((off & (sz - 1)) == 0) begin
              // No check for a block that is already free: it is simply pushed again.
              idx                = 4'(off / sz);
              s.links[c][idx]    = s.head[c];
              s.head[c]          = idx;
              r.cls              = 2'(c);
              r.status           = ST_OK;
            end
          end else begin
            off = off - span;
          end
        end
      end
    end
    return r;
  endfunction

  // Appends a request for the driver and advances the generator's image, remembering any
  // address that the block is expected to grant.
  task automatic queue_request(input func_e op, input logic [15:0] bytes,
                               input logic [31:0] addr);
    grant_t    r;
    pool_req_t q;
    r = pool_serve(gen_state, op, bytes, addr);
    if (op == FUNC_ALLOC && r.status == ST_OK) live_q.push_back(r.granted);
    q.op    = op;
    q.bytes = bytes;
    q.addr  = addr;
    req_q.push_back(q);
  endtask

  // Mostly allocates and frees of granted blocks, so that the lists fill, empty and refill;
  // the rest are frees of arbitrary blocks (repeats and cycles in the lists) and bad addresses.
  task automatic queue_random_item();
    int unsigned pick;
    int unsigned c;
    int unsigned pos;
    logic [15:0] bytes;
    logic [31:0] addr;
    pick = $urandom_range(99);
    if (live_q.size() == 0 || pick < 50) begin
      case ($urandom_range(9))
        0, 1, 2: bytes = 16'($urandom_range(8, 0));
        3, 4:    bytes = 16'($urandom_range(24, 9));
        5, 6:    bytes = 16'($urandom_range(56, 25));
        7:       bytes = 16'($urandom_range(65535, 57));
        default: bytes = 16'($urandom());
      endcase
      queue_request(FUNC_ALLOC, bytes, $urandom());
    end else if (pick < 85) begin
      pos  = $urandom_range(live_q.size() - 1);
      addr = live_q[pos];
      live_q.delete(pos);
      queue_request(FUNC_FREE, 16'($urandom()), addr);
    end else if (pick < 93) begin
      c = $urandom_range(2);
      queue_request(FUNC_FREE, 16'($urandom()),
                    block_addr(gen_state.base, c, $urandom_range(class_count(c) - 1)));
    end else begin
      c = $urandom_range(2);
      if ($urandom_range(1) == 0) addr = $urandom();
      else addr = block_addr(gen_state.base, c, $urandom_range(class_count(c) - 1)) +
                  $urandom_range(class_size(c) - 1, 1);
      queue_request(FUNC_FREE, 16'($urandom()), addr);
    end
  endtask

  // Returns once every request has been accepted and every result has arrived, plus a margin.
  task automatic wait_idle();
    while (req_q.size() != 0 || start || grant_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes pool_base while the block is idle, then reads it back over the same port.
  task automatic pool_base_write(input logic [31:0] value);
    logic [31:0] readback;
    wait_idle();
    // Blocks keep their indices across a base change, so live addresses move with the base.
    for (int i = 0; i < live_q.size(); i++) live_q[i] = live_q[i] + (value - gen_state.base);
    gen_state.base = value;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_POOL_BASE;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) begin
      err_count++;
      $display("%0t: pool_base readback expected %h actual %h", $time, value, readback);
    end
  endtask

  // Driver: a request stays on the ports until an edge accepts it; then the next one is
  // offered, unless the sender idles in this cycle.
  always @(negedge clk_i) begin
    pool_req_t q;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        q                = req_q.pop_front();
        start           <= 1'b1;
        func_i          <= q.op;
        request_bytes_i <= q.bytes;
        block_address_i <= q.addr;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: applies register writes to the checker's image, predicts each accepted request
  // and compares every result strobe with the oldest prediction.
  always @(posedge clk_i) begin
    grant_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (psel && penable && pwrite && pready && paddr == ADDR_POOL_BASE) begin
        chk_state.base = pwdata;
      end
      if (start && !busy) begin
        grant_q.push_back(pool_serve(chk_state, func_e'(func_i), request_bytes_i,
                                     block_address_i));
      end
      if (result_valid_o) begin
        if (grant_q.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected: address %h class %0d status %0d",
                   $time, granted_address_o, size_class_o, status_o);
        end else begin
          want = grant_q.pop_front();
          if (granted_address_o !== want.granted) begin
            err_count++;
            $display("%0t: granted_address expected %h actual %h",
                     $time, want.granted, granted_address_o);
          end
          if (size_class_o !== want.cls) begin
            err_count++;
            $display("%0t: size_class expected %0d actual %0d", $time, want.cls, size_class_o);
          end
          if (status_o !== want.status) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] base_val;
    chk_state = pool_reset_state();
    gen_state = pool_reset_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Phase 0 rewrites the reset value of zero and runs the directed requests without gaps.
    pool_base_write(32'h0000_0000);
    @(posedge clk_i);
    idle_pct = 0;
    // Class boundaries: the largest request of each class, the smallest of the next,
    // and requests too large for any class.
    queue_request(FUNC_ALLOC, 16'd0, 32'hFFFF_FFFF);
    queue_request(FUNC_ALLOC, 16'd8, 32'h0000_0000);
    queue_request(FUNC_ALLOC, 16'd9, 32'hAAAA_AAAA);
    queue_request(FUNC_ALLOC, 16'd24, 32'h5555_5555);
    queue_request(FUNC_ALLOC, 16'd25, 32'h0000_0000);
    queue_request(FUNC_ALLOC, 16'd56, 32'h0000_0000);
    queue_request(FUNC_ALLOC, 16'd57, 32'h0000_0000);
    queue_request(FUNC_ALLOC, 16'hFFFF, 32'h0000_0000);
    // Frees: a good one, then the same block again, one per other class, then addresses
    // below the pool, misaligned, just past its end and at the top of the address space.
    queue_request(FUNC_FREE, 16'hFFFF, block_addr(gen_state.base, 0, 0));
    queue_request(FUNC_FREE, 16'h0000, block_addr(gen_state.base, 0, 0));
    queue_request(FUNC_FREE, 16'h0000, block_addr(gen_state.base, 1, 0));
    queue_request(FUNC_FREE, 16'h0000, block_addr(gen_state.base, 2, 1));
    queue_request(FUNC_FREE, 16'h0000, gen_state.base);
    queue_request(FUNC_FREE, 16'h0000, block_addr(gen_state.base, 0, 1) + 1);
    queue_request(FUNC_FREE, 16'h0000, block_addr(gen_state.base, 2, LARGE_BLOCKS));
    queue_request(FUNC_FREE, 16'h0000, 32'hFFFF_FFFF);
    // Drain the large class until it reports exhaustion; no smaller or larger class is tried.
    repeat (4) queue_request(FUNC_ALLOC, 16'd40, $urandom());
    repeat (RANDOM_PER_PHASE) queue_random_item();

    // Later phases move the pool, including placements that wrap past the top of the
    // address space, and vary how often the sender idles.
    for (int p = 1; p < PHASE_COUNT; p++) begin
      case (p)
        1:       base_val = 32'hFFFF_FFC0;
        2:       base_val = 32'hFFFF_FFFF;
        5:       base_val = 32'h0000_0000;
        default: base_val = $urandom();
      endcase
      pool_base_write(base_val);
      @(posedge clk_i);
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 75;
        default: idle_pct = 27;
      endcase
      repeat (RANDOM_PER_PHASE) queue_random_item();
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
